// ===== rtl/core/pdt_pkg.sv =====
// Shared types, constants and helper functions of the PD position to body thrust block.
// Used by the channel interfaces, the divider, the top level and the checker.
package pdt_pkg;

    localparam int PosW    = 32;
    localparam int QuatW   = 16;
    localparam int GainW   = 16;
    localparam int DelayW  = 10;
    localparam int TickW   = 11;
    localparam int ThrW    = 16;
    localparam int CfgIdxW = 3;
    localparam int CfgW    = 16;

    localparam int MaW     = 35;
    localparam int MbW     = 18;
    localparam int ProdW   = MaW + MbW;
    localparam int AccW    = 53;
    localparam int QpW     = 32;
    localparam int MatW    = 34;
    localparam int NumW    = 50;
    localparam int NormW   = 33;
    localparam int DivW    = 53;
    localparam int QuoW    = 17;

    localparam logic [CfgIdxW-1:0] CFG_GAIN_P    = 3'd0;
    localparam logic [CfgIdxW-1:0] CFG_GAIN_D    = 3'd1;
    localparam logic [CfgIdxW-1:0] CFG_REF_QW    = 3'd2;
    localparam logic [CfgIdxW-1:0] CFG_REF_QX    = 3'd3;
    localparam logic [CfgIdxW-1:0] CFG_REF_QY    = 3'd4;
    localparam logic [CfgIdxW-1:0] CFG_REF_QZ    = 3'd5;
    localparam logic [CfgIdxW-1:0] CFG_ARM_DELAY = 3'd6;

    localparam logic [GainW-1:0]         GAIN_RESET      = 16'd256;
    localparam logic signed [QuatW-1:0]  REF_QW_RESET    = 16'sd16384;
    localparam logic [DelayW-1:0]        ARM_DELAY_RESET = 10'd50;

    localparam logic signed [AccW-1:0]   HOVER_Q24 = 53'sd3355443;
    localparam logic signed [AccW-1:0]   ONE_Q24   = 53'sd16777216;
    localparam logic signed [AccW-1:0]   HALF_LSB  = 53'sd512;
    localparam logic signed [ThrW-1:0]   THR_MAX   = 16'sd16384;

    typedef struct packed {
        logic                    func;
        logic signed [PosW-1:0]  pos_x;
        logic signed [PosW-1:0]  pos_y;
        logic signed [PosW-1:0]  pos_z;
        logic signed [PosW-1:0]  vel_x;
        logic signed [PosW-1:0]  vel_y;
        logic signed [PosW-1:0]  vel_z;
        logic signed [QuatW-1:0] att_w;
        logic signed [QuatW-1:0] att_x;
        logic signed [QuatW-1:0] att_y;
        logic signed [QuatW-1:0] att_z;
        logic                    offboard_now;
    } t_in_item;

    typedef struct packed {
        logic                    setpoint_valid;
        logic signed [ThrW-1:0]  thrust_x;
        logic signed [ThrW-1:0]  thrust_y;
        logic signed [ThrW-1:0]  thrust_z;
        logic signed [QuatW-1:0] setpoint_qw;
        logic signed [QuatW-1:0] setpoint_qx;
        logic signed [QuatW-1:0] setpoint_qy;
        logic signed [QuatW-1:0] setpoint_qz;
        logic                    arm_request;
    } t_out_item;

    typedef struct packed {
        logic                   start;
        logic signed [NumW-1:0] num;
        logic [NormW-1:0]       norm;
    } t_div_req;

    typedef struct packed {
        logic                   done;
        logic signed [ThrW-1:0] quo;
    } t_div_rsp;

    // Clamp a Q29.24 sum to [-1, 1] and round it to Q2.14.
    function automatic logic signed [ThrW-1:0] f_round(input logic signed [AccW-1:0] s);
        logic signed [AccW-1:0] c;
        logic signed [AccW-1:0] v;
        logic signed [17:0]     d;
        if (s > ONE_Q24) begin
            c = ONE_Q24;
        end else if (s < -ONE_Q24) begin
            c = -ONE_Q24;
        end else begin
            c = s;
        end
        v = c + ONE_Q24 + HALF_LSB;
        d = $signed({1'b0, v[26:10]}) - 18'sd16384;
        return $signed(d[ThrW-1:0]);
    endfunction

    // Negation that maps the most negative value to the most positive one.
    function automatic logic signed [QuatW-1:0] f_neg16(input logic signed [QuatW-1:0] v);
        return (v == 16'sh8000) ? 16'sh7fff : -v;
    endfunction

endpackage

// ===== rtl/core/pdt_if.sv =====
// Valid/ready channel interfaces for input items, result items and register writes.
// Depends on pdt_pkg for the payload types.
interface pdt_item_if;
    logic              valid;
    logic              ready;
    pdt_pkg::t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface pdt_result_if;
    logic               valid;
    logic               ready;
    pdt_pkg::t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface pdt_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [pdt_pkg::CfgIdxW-1:0]   index;
    logic [pdt_pkg::CfgW-1:0]      data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/pd_position_to_body_thrust.sv =====
// Top level: PD position controller whose thrust is rotated into the body frame.
// Depends on pdt_pkg, the channel interfaces in pdt_if and the divider pdt_div.
//
//   Port      Dir  Transaction
//   i_cfg     in   register write: index 0..6, 16-bit data (index 7 is ignored)
//   i_item    in   control tick (func 0) or set-target item (func 1)
//   o_result  out  one setpoint per control tick, none per set-target item
//
// A set-target item only updates the held target and leaves the block idle. In a control tick
// one shared 35x18 multiplier runs six PD products, ten quaternion products and nine matrix
// products, then a bit-serial divider works on each of three components; the matrix products
// and divisions are skipped when the attitude is all zero.
// i_item is not ready while a tick is worked on, and the result register holds a finished
// setpoint until o_result is taken, which stalls the next tick in its last state.
// Reset is synchronous and needs no sweep.
module pd_position_to_body_thrust (
    input logic           i_clk,
    input logic           i_rst_n,
    pdt_cfg_if.sink       i_cfg,
    pdt_item_if.sink      i_item,
    pdt_result_if.source  o_result
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_PD     = 3'd1;
    localparam logic [2:0] S_QP     = 3'd2;
    localparam logic [2:0] S_NORM   = 3'd3;
    localparam logic [2:0] S_MAT    = 3'd4;
    localparam logic [2:0] S_DSTART = 3'd5;
    localparam logic [2:0] S_DWAIT  = 3'd6;
    localparam logic [2:0] S_OUT    = 3'd7;

    localparam int QP_WW = 0;
    localparam int QP_XX = 1;
    localparam int QP_YY = 2;
    localparam int QP_ZZ = 3;
    localparam int QP_XY = 4;
    localparam int QP_WZ = 5;
    localparam int QP_XZ = 6;
    localparam int QP_WY = 7;
    localparam int QP_YZ = 8;
    localparam int QP_WX = 9;

    logic [2:0]                             r_state;
    logic [1:0]                             r_i;
    logic [1:0]                             r_j;
    logic [3:0]                             r_k;

    logic [pdt_pkg::GainW-1:0]              r_gain_p;
    logic [pdt_pkg::GainW-1:0]              r_gain_d;
    logic signed [pdt_pkg::QuatW-1:0]       r_ref_qw;
    logic signed [pdt_pkg::QuatW-1:0]       r_ref_qx;
    logic signed [pdt_pkg::QuatW-1:0]       r_ref_qy;
    logic signed [pdt_pkg::QuatW-1:0]       r_ref_qz;
    logic [pdt_pkg::DelayW-1:0]             r_arm_delay;

    logic signed [pdt_pkg::PosW-1:0]        r_hold [3];
    logic                                   r_was_off;
    logic [pdt_pkg::TickW-1:0]              r_tick;

    logic signed [pdt_pkg::PosW-1:0]        r_pos [3];
    logic signed [pdt_pkg::PosW-1:0]        r_vel [3];
    logic signed [pdt_pkg::QuatW-1:0]       r_att [4];
    logic                                   r_off;
    logic                                   r_arm;

    logic signed [pdt_pkg::AccW-1:0]        r_acc;
    logic signed [pdt_pkg::ThrW-1:0]        r_t [3];
    logic signed [pdt_pkg::QpW-1:0]         r_qp [10];
    logic [pdt_pkg::NormW-1:0]              r_norm;
    logic signed [pdt_pkg::NumW-1:0]        r_num [3];
    logic signed [pdt_pkg::ThrW-1:0]        r_b [3];

    pdt_pkg::t_out_item                     r_out;
    logic                                   r_out_valid;

    logic signed [pdt_pkg::MaW-1:0]         ma;
    logic signed [pdt_pkg::MbW-1:0]         mb;
    logic signed [pdt_pkg::ProdW-1:0]       prod;
    logic signed [pdt_pkg::PosW:0]          err;
    logic signed [pdt_pkg::MatW-1:0]        mat [3][3];
    logic signed [pdt_pkg::MatW-1:0]        qe [10];
    logic [pdt_pkg::NormW-1:0]              norm_sum;
    logic signed [pdt_pkg::AccW-1:0]        acc_next;
    logic                                   in_acc;
    pdt_pkg::t_div_req                      div_req;
    pdt_pkg::t_div_rsp                      div_rsp;

    assign i_cfg.ready  = 1'b1;
    assign i_item.ready = (r_state == S_IDLE);
    assign in_acc       = i_item.valid && (r_state == S_IDLE);

    assign err = {r_pos[r_i][pdt_pkg::PosW-1], r_pos[r_i]}
               - {r_hold[r_i][pdt_pkg::PosW-1], r_hold[r_i]};

    always_comb begin
        for (int e = 0; e < 10; e++) begin
            qe[e] = pdt_pkg::MatW'(r_qp[e]);
        end
        mat[0][0] = qe[QP_WW] + qe[QP_XX] - qe[QP_YY] - qe[QP_ZZ];
        mat[0][1] = (qe[QP_XY] + qe[QP_WZ]) <<< 1;
        mat[0][2] = (qe[QP_XZ] - qe[QP_WY]) <<< 1;
        mat[1][0] = (qe[QP_XY] - qe[QP_WZ]) <<< 1;
        mat[1][1] = qe[QP_WW] - qe[QP_XX] + qe[QP_YY] - qe[QP_ZZ];
        mat[1][2] = (qe[QP_YZ] + qe[QP_WX]) <<< 1;
        mat[2][0] = (qe[QP_XZ] + qe[QP_WY]) <<< 1;
        mat[2][1] = (qe[QP_YZ] - qe[QP_WX]) <<< 1;
        mat[2][2] = qe[QP_WW] - qe[QP_XX] - qe[QP_YY] + qe[QP_ZZ];
    end

    assign norm_sum = pdt_pkg::NormW'(r_qp[QP_WW]) + pdt_pkg::NormW'(r_qp[QP_XX])
                    + pdt_pkg::NormW'(r_qp[QP_YY]) + pdt_pkg::NormW'(r_qp[QP_ZZ]);

    // Operand selection for the shared multiplier.
    always_comb begin
        ma = '0;
        mb = '0;
        unique case (r_state)
            S_PD: begin
                if (r_j == 2'd0) begin
                    ma = pdt_pkg::MaW'(err);
                    mb = $signed({2'b00, r_gain_p});
                end else begin
                    ma = pdt_pkg::MaW'(r_vel[r_i]);
                    mb = $signed({2'b00, r_gain_d});
                end
            end
            S_QP: begin
                case (r_k)
                    4'd0: begin ma = pdt_pkg::MaW'(r_att[0]); mb = pdt_pkg::MbW'(r_att[0]); end
                    4'd1: begin ma = pdt_pkg::MaW'(r_att[1]); mb = pdt_pkg::MbW'(r_att[1]); end
                    4'd2: begin ma = pdt_pkg::MaW'(r_att[2]); mb = pdt_pkg::MbW'(r_att[2]); end
                    4'd3: begin ma = pdt_pkg::MaW'(r_att[3]); mb = pdt_pkg::MbW'(r_att[3]); end
                    4'd4: begin ma = pdt_pkg::MaW'(r_att[1]); mb = pdt_pkg::MbW'(r_att[2]); end
                    4'd5: begin ma = pdt_pkg::MaW'(r_att[0]); mb = pdt_pkg::MbW'(r_att[3]); end
                    4'd6: begin ma = pdt_pkg::MaW'(r_att[1]); mb = pdt_pkg::MbW'(r_att[3]); end
                    4'd7: begin ma = pdt_pkg::MaW'(r_att[0]); mb = pdt_pkg::MbW'(r_att[2]); end
                    4'd8: begin ma = pdt_pkg::MaW'(r_att[2]); mb = pdt_pkg::MbW'(r_att[3]); end
                    default: begin ma = pdt_pkg::MaW'(r_att[0]); mb = pdt_pkg::MbW'(r_att[1]); end
                endcase
            end
            S_MAT: begin
                ma = pdt_pkg::MaW'(mat[r_i][r_j]);
                mb = pdt_pkg::MbW'(r_t[r_j]);
            end
            default: begin
                ma = '0;
                mb = '0;
            end
        endcase
    end

    assign prod     = ma * mb;
    assign acc_next = (r_j == 2'd0) ? prod : r_acc + prod;

    assign div_req.start = (r_state == S_DSTART);
    assign div_req.num   = r_num[r_i];
    assign div_req.norm  = r_norm;

    pdt_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_p    <= pdt_pkg::GAIN_RESET;
            r_gain_d    <= pdt_pkg::GAIN_RESET;
            r_ref_qw    <= pdt_pkg::REF_QW_RESET;
            r_ref_qx    <= '0;
            r_ref_qy    <= '0;
            r_ref_qz    <= '0;
            r_arm_delay <= pdt_pkg::ARM_DELAY_RESET;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                pdt_pkg::CFG_GAIN_P:    r_gain_p    <= i_cfg.data;
                pdt_pkg::CFG_GAIN_D:    r_gain_d    <= i_cfg.data;
                pdt_pkg::CFG_REF_QW:    r_ref_qw    <= $signed(i_cfg.data);
                pdt_pkg::CFG_REF_QX:    r_ref_qx    <= $signed(i_cfg.data);
                pdt_pkg::CFG_REF_QY:    r_ref_qy    <= $signed(i_cfg.data);
                pdt_pkg::CFG_REF_QZ:    r_ref_qz    <= $signed(i_cfg.data);
                pdt_pkg::CFG_ARM_DELAY: r_arm_delay <= i_cfg.data[pdt_pkg::DelayW-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_i         <= '0;
            r_j         <= '0;
            r_k         <= '0;
            r_hold[0]   <= '0;
            r_hold[1]   <= '0;
            r_hold[2]   <= '0;
            r_was_off   <= 1'b0;
            r_tick      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_result.valid && o_result.ready && (r_state != S_OUT)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        if (i_item.data.func) begin
                            r_hold[0] <= i_item.data.pos_y;
                            r_hold[1] <= (i_item.data.pos_x == 32'sh8000_0000)
                                       ? 32'sh7fff_ffff : -i_item.data.pos_x;
                            r_hold[2] <= i_item.data.pos_z;
                        end else begin
                            if (i_item.data.offboard_now && !r_was_off) begin
                                r_hold[0] <= i_item.data.pos_x;
                                r_hold[1] <= i_item.data.pos_y;
                                r_hold[2] <= i_item.data.pos_z;
                            end
                            r_was_off <= i_item.data.offboard_now;
                            r_pos[0]  <= i_item.data.pos_x;
                            r_pos[1]  <= i_item.data.pos_y;
                            r_pos[2]  <= i_item.data.pos_z;
                            r_vel[0]  <= i_item.data.vel_x;
                            r_vel[1]  <= i_item.data.vel_y;
                            r_vel[2]  <= i_item.data.vel_z;
                            r_att[0]  <= i_item.data.att_w;
                            r_att[1]  <= i_item.data.att_x;
                            r_att[2]  <= i_item.data.att_y;
                            r_att[3]  <= i_item.data.att_z;
                            r_off     <= i_item.data.offboard_now;
                            r_arm     <= (r_tick == pdt_pkg::TickW'(r_arm_delay));
                            if (r_tick <= pdt_pkg::TickW'(r_arm_delay)) begin
                                r_tick <= r_tick + 1'b1;
                            end
                            r_i     <= '0;
                            r_j     <= '0;
                            r_state <= S_PD;
                        end
                    end
                end
                S_PD: begin
                    if (r_j == 2'd0) begin
                        r_acc <= ((r_i == 2'd2) ? pdt_pkg::HOVER_Q24 : '0) - prod;
                        r_j   <= 2'd1;
                    end else if (r_j == 2'd1) begin
                        r_acc <= r_acc - prod;
                        r_j   <= 2'd2;
                    end else begin
                        r_t[r_i] <= pdt_pkg::f_round(r_acc);
                        r_j      <= '0;
                        if (r_i == 2'd2) begin
                            r_k     <= '0;
                            r_state <= S_QP;
                        end else begin
                            r_i <= r_i + 1'b1;
                        end
                    end
                end
                S_QP: begin
                    r_qp[r_k] <= prod[pdt_pkg::QpW-1:0];
                    if (r_k == 4'd9) begin
                        r_state <= S_NORM;
                    end else begin
                        r_k <= r_k + 1'b1;
                    end
                end
                S_NORM: begin
                    r_norm <= norm_sum;
                    r_i    <= '0;
                    r_j    <= '0;
                    if (norm_sum == '0) begin
                        r_b[0]  <= r_t[0];
                        r_b[1]  <= r_t[1];
                        r_b[2]  <= r_t[2];
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_MAT;
                    end
                end
                S_MAT: begin
                    r_acc <= acc_next;
                    if (r_j == 2'd2) begin
                        r_num[r_i] <= acc_next[pdt_pkg::NumW-1:0];
                        r_j        <= '0;
                        if (r_i == 2'd2) begin
                            r_i     <= '0;
                            r_state <= S_DSTART;
                        end else begin
                            r_i <= r_i + 1'b1;
                        end
                    end else begin
                        r_j <= r_j + 1'b1;
                    end
                end
                S_DSTART: begin
                    r_state <= S_DWAIT;
                end
                S_DWAIT: begin
                    if (div_rsp.done) begin
                        r_b[r_i] <= div_rsp.quo;
                        if (r_i == 2'd2) begin
                            r_state <= S_OUT;
                        end else begin
                            r_i     <= r_i + 1'b1;
                            r_state <= S_DSTART;
                        end
                    end
                end
                S_OUT: begin
                    if (!r_out_valid || o_result.ready) begin
                        r_out_valid          <= 1'b1;
                        r_out.setpoint_valid <= r_off;
                        r_out.thrust_x       <= r_off ? r_b[0] : '0;
                        r_out.thrust_y       <= r_off ? -r_b[1] : '0;
                        r_out.thrust_z       <= r_off ? -r_b[2] : '0;
                        r_out.setpoint_qw    <= r_off ? r_ref_qw : '0;
                        r_out.setpoint_qx    <= r_off ? r_ref_qx : '0;
                        r_out.setpoint_qy    <= r_off ? pdt_pkg::f_neg16(r_ref_qy) : '0;
                        r_out.setpoint_qz    <= r_off ? pdt_pkg::f_neg16(r_ref_qz) : '0;
                        r_out.arm_request    <= r_arm;
                        r_state              <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_result.valid = r_out_valid;
    assign o_result.data  = r_out;

endmodule

// ===== rtl/core/pdt_div.sv =====
// Restoring divider with round-to-nearest and saturation of the body thrust components.
// Depends on pdt_pkg; one quotient bit is resolved per cycle.
module pdt_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  pdt_pkg::t_div_req i_req,
    output pdt_pkg::t_div_rsp o_rsp
);

    logic                            r_busy;
    logic                            r_done;
    logic [4:0]                      r_cnt;
    logic [pdt_pkg::DivW-1:0]        r_rem;
    logic [pdt_pkg::NormW:0]         r_den;
    logic [pdt_pkg::QuoW-1:0]        r_q;
    logic                            r_ovf;
    logic                            r_neg;

    logic [pdt_pkg::NumW-1:0]        mag;
    logic [pdt_pkg::DivW-1:0]        shifted;
    logic                            ge;
    logic [pdt_pkg::ThrW-1:0]        qmag;

    assign mag     = i_req.num[pdt_pkg::NumW-1] ? pdt_pkg::NumW'(-i_req.num)
                                                : pdt_pkg::NumW'(i_req.num);
    assign shifted = pdt_pkg::DivW'(r_den) << r_cnt;
    assign ge      = (r_rem >= shifted);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'd17;
                r_rem  <= (pdt_pkg::DivW'(mag) << 1) + pdt_pkg::DivW'(i_req.norm);
                r_den  <= {i_req.norm, 1'b0};
                r_q    <= '0;
                r_ovf  <= 1'b0;
                r_neg  <= i_req.num[pdt_pkg::NumW-1];
            end else if (r_busy) begin
                if (r_cnt == 5'd17) begin
                    r_ovf <= ge;
                end else begin
                    r_q <= {r_q[pdt_pkg::QuoW-2:0], ge};
                    if (ge) begin
                        r_rem <= r_rem - shifted;
                    end
                end
                if (r_cnt == 5'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 5'd1;
                end
            end
        end
    end

    assign qmag = (r_ovf || (r_q > pdt_pkg::QuoW'(pdt_pkg::THR_MAX)))
                ? pdt_pkg::THR_MAX : r_q[pdt_pkg::ThrW-1:0];

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_neg ? -$signed(qmag) : $signed(qmag);

endmodule

// ===== rtl/core/pdt_chk.sv =====
// Port-level checker for the PD position to body thrust block, attached by bind.
// Depends on pdt_pkg for the result and item types.
module pdt_chk (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               i_in_ready,
    input pdt_pkg::t_in_item  i_in_data,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input pdt_pkg::t_out_item i_out_data
);

    // A stalled result transaction keeps its valid.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result valid dropped while stalled");

    // After a control tick is taken, the block is not ready in the cycle after.
    a_tick_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && !i_in_data.func |=> !i_in_ready)
        else $error("input ready right after a control tick");

    // Outside offboard the setpoint payload is zero.
    a_zero_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_data.setpoint_valid |->
            i_out_data.thrust_x == '0 && i_out_data.thrust_y == '0 &&
            i_out_data.thrust_z == '0 && i_out_data.setpoint_qw == '0)
        else $error("nonzero setpoint outside offboard");

    // Body thrust stays within the saturation range.
    a_thr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |->
            i_out_data.thrust_x <= pdt_pkg::THR_MAX && i_out_data.thrust_x >= -pdt_pkg::THR_MAX &&
            i_out_data.thrust_y <= pdt_pkg::THR_MAX && i_out_data.thrust_y >= -pdt_pkg::THR_MAX &&
            i_out_data.thrust_z <= pdt_pkg::THR_MAX && i_out_data.thrust_z >= -pdt_pkg::THR_MAX)
        else $error("body thrust out of range");

endmodule

bind pd_position_to_body_thrust pdt_chk u_pdt_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_item.valid),
    .i_in_ready  (i_item.ready),
    .i_in_data   (i_item.data),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready),
    .i_out_data  (o_result.data)
);
